// ----- hw/rtl/gyp_pkg.sv -----
// Shared types and constants for the gaze yaw/pitch CORDIC pipeline.
// No dependencies; imported by gyp_cordic, gyp_gain and the top level.
package gyp_pkg;

    // Width of every external field.
    localparam int FIELD_W = 16;

    // Angle accumulator: units of pi/2^31 rad, with headroom above a half turn.
    localparam int ANG_W = 34;
    typedef logic signed [ANG_W-1:0] ang_t;

    // Fraction bits added to the coordinates inside the datapath.
    localparam int FRAC_BITS = 4;

    // Output angle = (acc + 2^15) >> 16.
    localparam int   ANG_SHIFT = 16;
    localparam ang_t ROUND_ACC = 34'sd32768;

    // Start angle of the left-half-plane pre-rotation (a quarter turn).
    localparam ang_t QUARTER_ACC = 34'sd1073741824;

    // Pitch clamp limits: a quarter turn in output units.
    localparam ang_t                       PITCH_LIM_ACC = 34'sd16384;
    localparam logic signed [FIELD_W-1:0]  PITCH_MAX     = 16'sd16384;
    localparam logic signed [FIELD_W-1:0]  PITCH_MIN     = -16'sd16384;

    // atan(2^-i) in units of pi/2^31 rad, rounded to nearest.
    localparam int TAB_LEN = 24;
    localparam int TAB_W   = 30;
    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Inverse CORDIC gain, Q0.24; result rounded half up before the shift.
    localparam int                GAIN_W     = 24;
    localparam int                GAIN_SHIFT = 24;
    localparam logic [GAIN_W-1:0] GAIN_INV   = 24'd10188014;

endpackage

// ----- hw/rtl/gaze_yaw_pitch_from_point_top.sv -----
// Gaze yaw/pitch from a camera-frame target point: two CORDIC vectoring passes.
// Depends on gyp_pkg, gyp_cordic and gyp_gain.
//
//   channel  | ports                                      | direction
//   ---------+--------------------------------------------+----------
//   input    | s_valid s_ready s_target_x/_y/_z           | in
//   result   | m_valid m_ready m_yaw_angle m_pitch_angle  | out
//
// Pipeline: input register, STEPS yaw stages, two gain stages, STEPS pitch
// stages, output register; STEPS = CORDIC_STEPS capped at 24. One item enters
// per cycle unless halted: each CORDIC stage does one micro-rotation.
// Reset (aresetn low, synchronous) clears the valid bits only.
// The pipeline moves as one; it halts only when its last stage holds an item
// and the output register holds an item not taken, so bubbles still drain.
module gaze_yaw_pitch_from_point_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gyp_pkg::FIELD_W-1:0]   s_target_x,
    input  logic signed [gyp_pkg::FIELD_W-1:0]   s_target_y,
    input  logic signed [gyp_pkg::FIELD_W-1:0]   s_target_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gyp_pkg::FIELD_W-1:0]   m_yaw_angle,
    output logic signed [gyp_pkg::FIELD_W-1:0]   m_pitch_angle
);
    import gyp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    // Scaled coordinate, CORDIC gain growth and a guard bit.
    localparam int XW    = CW + 8;
    localparam int ZW    = CW + FRAC_BITS;
    localparam int SW1   = ZW + 1;
    localparam int SW2   = ZW + FIELD_W;
    localparam int SW3   = 3 + FIELD_W;

    // ---------------- handshake ----------------
    logic en;
    logic out_take;
    logic p2_valid;

    logic                        m_valid_reg;
    logic signed [FIELD_W-1:0]   m_yaw_angle_reg;
    logic signed [FIELD_W-1:0]   m_pitch_angle_reg;

    // Output register takes a new item when empty or being drained.
    assign out_take = !m_valid_reg || m_ready;
    // Advance everything unless the last stage would overwrite a held result.
    assign en       = !p2_valid || out_take;
    assign s_ready  = en;

    // ---------------- input stage ----------------
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;

    // Coordinates come from the low CW bits; wider formats zero-extend.
    if (CW <= FIELD_W) begin : g_narrow
        assign cx = s_target_x[CW-1:0];
        assign cy = s_target_y[CW-1:0];
        assign cz = s_target_z[CW-1:0];
    end else begin : g_wide
        assign cx = signed'({{(CW-FIELD_W){1'b0}}, s_target_x});
        assign cy = signed'({{(CW-FIELD_W){1'b0}}, s_target_y});
        assign cz = signed'({{(CW-FIELD_W){1'b0}}, s_target_z});
    end

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] zs;
    logic signed [XW-1:0] x0_next;
    logic signed [XW-1:0] y0_next;
    ang_t                 a0_next;
    logic                 xy0_zero_next;

    assign xs = {{(XW-ZW){cx[CW-1]}}, cx, {FRAC_BITS{1'b0}}};
    assign ys = {{(XW-ZW){cy[CW-1]}}, cy, {FRAC_BITS{1'b0}}};
    assign zs = {cz, {FRAC_BITS{1'b0}}};

    // Left half plane: pre-rotate by a quarter turn so the passes converge.
    always_comb begin
        x0_next       = xs;
        y0_next       = ys;
        a0_next       = '0;
        xy0_zero_next = (xs == '0) && (ys == '0);
        if (xs[XW-1]) begin
            if (!ys[XW-1]) begin
                x0_next = ys;
                y0_next = -xs;
                a0_next = QUARTER_ACC;
            end else begin
                x0_next = -ys;
                y0_next = xs;
                a0_next = -QUARTER_ACC;
            end
        end
    end

    logic                 v0_reg;
    logic signed [XW-1:0] x0_reg;
    logic signed [XW-1:0] y0_reg;
    ang_t                 a0_reg;
    logic signed [ZW-1:0] z0_reg;
    logic                 xy0_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg       <= x0_next;
            y0_reg       <= y0_next;
            a0_reg       <= a0_next;
            z0_reg       <= zs;
            xy0_zero_reg <= xy0_zero_next;
        end
    end

    // ---------------- yaw pass ----------------
    logic                 p1_valid;
    logic signed [XW-1:0] p1_x;
    ang_t                 p1_ang;
    logic [SW1-1:0]       p1_side;
    logic                 p1_xy_zero;
    logic signed [ZW-1:0] p1_z;

    gyp_cordic #(
        .XW    (XW),
        .STEPS (STEPS),
        .SW    (SW1)
    ) u_yaw_pass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .in_x      (x0_reg),
        .in_y      (y0_reg),
        .in_ang    (a0_reg),
        .in_side   ({xy0_zero_reg, z0_reg}),
        .out_valid (p1_valid),
        .out_x     (p1_x),
        .out_ang   (p1_ang),
        .out_side  (p1_side)
    );

    assign p1_xy_zero = p1_side[ZW];
    assign p1_z       = p1_side[ZW-1:0];

    // Round the yaw; origin of the horizontal plane gives zero yaw and zero radius.
    ang_t                        yaw_acc;
    logic signed [FIELD_W-1:0]   p1_yaw;
    logic signed [XW-1:0]        gain_in_x;

    assign yaw_acc   = p1_ang + ROUND_ACC;
    assign p1_yaw    = p1_xy_zero ? '0 : yaw_acc[ANG_SHIFT+FIELD_W-1:ANG_SHIFT];
    assign gain_in_x = p1_xy_zero ? '0 : p1_x;

    // ---------------- gain compensation ----------------
    logic                 g_valid;
    logic signed [XW-1:0] g_r;
    logic [SW2-1:0]       g_side;
    logic signed [ZW-1:0] g_z;
    logic [FIELD_W-1:0]   g_yaw;

    gyp_gain #(
        .XW (XW),
        .SW (SW2)
    ) u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p1_valid),
        .in_x      (gain_in_x),
        .in_side   ({p1_z, p1_yaw}),
        .out_valid (g_valid),
        .out_r     (g_r),
        .out_side  (g_side)
    );

    assign g_z   = g_side[SW2-1:FIELD_W];
    assign g_yaw = g_side[FIELD_W-1:0];

    // ---------------- pitch pass ----------------
    logic                 g_r_zero;
    logic                 g_z_pos;
    logic                 g_z_neg;
    logic signed [XW-1:0] g_z_ext;

    assign g_r_zero = (g_r == '0);
    assign g_z_neg  = g_z[ZW-1];
    assign g_z_pos  = !g_z[ZW-1] && (g_z != '0);
    assign g_z_ext  = {{(XW-ZW){g_z[ZW-1]}}, g_z};

    logic signed [XW-1:0] p2_x;
    ang_t                 p2_ang;
    logic [SW3-1:0]       p2_side;

    gyp_cordic #(
        .XW    (XW),
        .STEPS (STEPS),
        .SW    (SW3)
    ) u_pitch_pass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_valid),
        .in_x      (g_r),
        .in_y      (g_z_ext),
        .in_ang    ('0),
        .in_side   ({g_r_zero, g_z_pos, g_z_neg, g_yaw}),
        .out_valid (p2_valid),
        .out_x     (p2_x),
        .out_ang   (p2_ang),
        .out_side  (p2_side)
    );

    // ---------------- output stage ----------------
    logic                        p2_r_zero;
    logic                        p2_z_pos;
    logic                        p2_z_neg;
    ang_t                        pitch_acc;
    ang_t                        pitch_full;
    logic signed [FIELD_W-1:0]   pitch_next;

    assign p2_r_zero  = p2_side[FIELD_W+2];
    assign p2_z_pos   = p2_side[FIELD_W+1];
    assign p2_z_neg   = p2_side[FIELD_W];
    assign pitch_acc  = p2_ang + ROUND_ACC;
    assign pitch_full = pitch_acc >>> ANG_SHIFT;

    // Zero radius: straight up, straight down or level. Otherwise clamp overshoot.
    always_comb begin
        priority if (p2_r_zero) begin
            pitch_next = p2_z_pos ? PITCH_MAX : (p2_z_neg ? PITCH_MIN : '0);
        end else if (pitch_full > PITCH_LIM_ACC) begin
            pitch_next = PITCH_MAX;
        end else if (pitch_full < -PITCH_LIM_ACC) begin
            pitch_next = PITCH_MIN;
        end else begin
            pitch_next = pitch_full[FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= p2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take && p2_valid) begin
            m_yaw_angle_reg   <= p2_side[FIELD_W-1:0];
            m_pitch_angle_reg <= pitch_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_yaw_angle   = m_yaw_angle_reg;
    assign m_pitch_angle = m_pitch_angle_reg;

    // ---------------- assertions ----------------
    // Vectoring never shrinks x; a negative magnitude means a width overflow.
    a_yaw_mag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid |-> !p1_x[XW-1])
        else $error("yaw pass magnitude went negative");

    a_gain_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        g_valid |-> !g_r[XW-1])
        else $error("compensated radius went negative");

    a_pitch_mag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid |-> !p2_x[XW-1])
        else $error("pitch pass magnitude went negative");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_pitch_angle_reg <= PITCH_MAX) && (m_pitch_angle_reg >= PITCH_MIN))
        else $error("pitch outside a quarter turn");

endmodule

// ----- hw/rtl/gyp_cordic.sv -----
// Unrolled CORDIC vectoring pipeline: one micro-rotation per register stage.
// Depends on gyp_pkg (angle type, arctangent table).
module gyp_cordic #(
    parameter int XW    = 24,
    parameter int STEPS = 16,
    parameter int SW    = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [XW-1:0]  in_x,
    input  logic signed [XW-1:0]  in_y,
    input  gyp_pkg::ang_t         in_ang,
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic signed [XW-1:0]  out_x,
    output gyp_pkg::ang_t         out_ang,
    output logic [SW-1:0]         out_side
);
    import gyp_pkg::*;

    logic                 v_reg    [STEPS];
    logic signed [XW-1:0] x_reg    [STEPS];
    logic signed [XW-1:0] y_reg    [STEPS-1];
    ang_t                 a_reg    [STEPS];
    logic [SW-1:0]        side_reg [STEPS];

    genvar g;
    for (g = 0; g < STEPS; g++) begin : g_step
        localparam ang_t STEP_ANG = ang_t'({{(ANG_W-TAB_W){1'b0}}, ATAN_TAB[g]});

        logic                 cv;
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        ang_t                 ca;
        logic [SW-1:0]        cs;
        logic signed [XW-1:0] x_next;
        ang_t                 a_next;

        if (g == 0) begin : g_first
            assign cv = in_valid;
            assign cx = in_x;
            assign cy = in_y;
            assign ca = in_ang;
            assign cs = in_side;
        end else begin : g_rest
            assign cv = v_reg[g-1];
            assign cx = x_reg[g-1];
            assign cy = y_reg[g-1];
            assign ca = a_reg[g-1];
            assign cs = side_reg[g-1];
        end

        // Rotate toward the x axis: sign of y picks the direction.
        always_comb begin
            if (!cy[XW-1]) begin
                x_next = cx + (cy >>> g);
                a_next = ca + STEP_ANG;
            end else begin
                x_next = cx - (cy >>> g);
                a_next = ca - STEP_ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= cv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g]    <= x_next;
                a_reg[g]    <= a_next;
                side_reg[g] <= cs;
            end
        end

        // The last stage drops y: only the magnitude and angle leave.
        if (g < STEPS - 1) begin : g_ypath
            logic signed [XW-1:0] y_next;

            always_comb begin
                if (!cy[XW-1]) begin
                    y_next = cy - (cx >>> g);
                end else begin
                    y_next = cy + (cx >>> g);
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    y_reg[g] <= y_next;
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_x     = x_reg[STEPS-1];
    assign out_ang   = a_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hw/rtl/gyp_gain.sv -----
// Two-stage CORDIC gain compensation: split multiply, then sum, round, shift.
// Depends on gyp_pkg (gain constant and shift).
module gyp_gain #(
    parameter int XW = 24,
    parameter int SW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [XW-1:0]  in_x,
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic signed [XW-1:0]  out_r,
    output logic [SW-1:0]         out_side
);
    import gyp_pkg::*;

    localparam int LO_W = XW / 2;
    localparam int HI_W = XW - LO_W;
    localparam int PL_W = LO_W + GAIN_W;
    localparam int PH_W = HI_W + GAIN_W + 1;
    localparam int PW   = XW + GAIN_W + 1;
    localparam logic signed [PW-1:0] RND =
        {{(PW-GAIN_SHIFT){1'b0}}, 1'b1, {(GAIN_SHIFT-1){1'b0}}};

    logic                   a_v_reg;
    logic [PL_W-1:0]        pl_reg;
    logic signed [PH_W-1:0] ph_reg;
    logic [SW-1:0]          a_side_reg;
    logic [PL_W-1:0]        pl_next;
    logic signed [PH_W-1:0] ph_next;

    logic                   b_v_reg;
    logic signed [XW-1:0]   r_reg;
    logic [SW-1:0]          b_side_reg;
    logic signed [PW-1:0]   sum;

    // Low half unsigned, high half signed: each product stays narrow.
    assign pl_next = PL_W'(in_x[LO_W-1:0]) * PL_W'(GAIN_INV);
    assign ph_next = PH_W'(signed'(in_x[XW-1:LO_W])) * PH_W'(signed'({1'b0, GAIN_INV}));

    assign sum = (PW'(ph_reg) <<< LO_W) + signed'(PW'(pl_reg)) + RND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            a_side_reg <= in_side;
            r_reg      <= sum[GAIN_SHIFT+XW-1:GAIN_SHIFT];
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_v_reg;
    assign out_r     = r_reg;
    assign out_side  = b_side_reg;

endmodule
